FILE: src/lie_pkg.sv
// ----------------------------------------------------------------------------
// lie_pkg
// Key codes, result kinds and sequencer states for the line input editor.
// ----------------------------------------------------------------------------
`default_nettype none

package lie_pkg;

    localparam int unsigned KEY_W       = 8;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned MAX_CHARS_W = 6;

    localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RST = 6'd39;

    localparam logic [KEY_W-1:0] KEY_CTRL_C = 8'd3;
    localparam logic [KEY_W-1:0] KEY_BS     = 8'd8;
    localparam logic [KEY_W-1:0] KEY_CR     = 8'd13;
    localparam logic [KEY_W-1:0] KEY_CTRL_X = 8'd24;
    localparam logic [KEY_W-1:0] KEY_ESC    = 8'd27;
    localparam logic [KEY_W-1:0] CHAR_NUL   = 8'd0;

    localparam logic [KIND_W-1:0] KIND_ECHO      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ECHO_BS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINE_CHAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CANCEL    = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_KILL = 5'b00100,
        S_LINE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: src/line_input_editor.sv
// ----------------------------------------------------------------------------
// line_input_editor
// Keyboard line editor: line buffer in a synchronous RAM, edit sequencer and
// a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one key code per transaction.
//   Output channel o_valid/i_ready carries result transactions (kind, char,
//   last); o_last marks the final result of a key. Keys that cause no result
//   (backspace or kill on an empty line, character on a full line) produce
//   nothing.
//   i_cfg_wr_en/i_cfg_wr_data write max_chars; write only while idle.
// Timing:
//   A key is taken in the idle state and executed from the EXEC state. Kill
//   emits one backspace echo per held character from the KILL state; enter
//   streams the held characters from the LINE state, then a done result from
//   the DONE state (only the done result on an empty line), with the RAM read
//   address set to the next emit index. The sequencer emits one result per
//   cycle, holding while a result waits in the output register; a new key
//   may still be taken while the final result of the last key waits.
// Reset:
//   Synchronous, active low: line empty, max_chars = 39, output empty.
//   The buffer RAM is not cleared; only written entries are ever emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module line_input_editor #(
    parameter int unsigned LINE_CAPACITY = 40
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [lie_pkg::MAX_CHARS_W-1:0]   i_cfg_wr_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [lie_pkg::KEY_W-1:0]         i_key_code,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [lie_pkg::KIND_W-1:0]             o_kind,
    output logic [lie_pkg::KEY_W-1:0]              o_char_out,
    output logic                                   o_last
);
    import lie_pkg::*;

    localparam int unsigned PW = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
    localparam int unsigned LW = (PW > MAX_CHARS_W) ? PW : MAX_CHARS_W;
    localparam logic [LW-1:0] CAP_LIMIT = LW'(LINE_CAPACITY - 1);

    t_state                 r_state, n_state;
    logic [MAX_CHARS_W-1:0] r_max_chars;
    logic [KEY_W-1:0]       r_key;
    logic [PW-1:0]          r_pos, n_pos;
    logic [PW-1:0]          r_idx, n_idx;
    logic [KEY_W-1:0]       r_rd_data;
    logic [KEY_W-1:0]       mem [LINE_CAPACITY];

    logic                   r_out_valid, n_out_valid;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [KEY_W-1:0]       r_char, n_char;
    logic                   r_last, n_last;

    logic                   slot_free;
    logic                   push;
    logic                   wr_en;
    logic                   room;

    assign slot_free = !r_out_valid || i_ready;
    assign room      = (LW'(r_pos) < LW'(r_max_chars)) && (LW'(r_pos) < CAP_LIMIT);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_idx   = r_idx;
        push    = 1'b0;
        wr_en   = 1'b0;
        n_kind  = r_kind;
        n_char  = r_char;
        n_last  = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    case (r_key) inside
                        KEY_BS: begin
                            if (r_pos != '0) begin
                                n_pos  = r_pos - 1'b1;
                                push   = 1'b1;
                                n_kind = KIND_ECHO_BS;
                                n_char = KEY_BS;
                                n_last = 1'b1;
                            end
                        end
                        KEY_CTRL_C, KEY_CTRL_X: begin
                            if (r_pos != '0) begin
                                n_state = S_KILL;
                            end
                        end
                        KEY_CR: begin
                            n_idx = '0;
                            if (r_pos != '0) begin
                                n_state = S_LINE;
                            end else begin
                                push   = 1'b1;
                                n_kind = KIND_DONE;
                                n_char = CHAR_NUL;
                                n_last = 1'b1;
                            end
                        end
                        KEY_ESC: begin
                            n_pos  = '0;
                            push   = 1'b1;
                            n_kind = KIND_CANCEL;
                            n_char = CHAR_NUL;
                            n_last = 1'b1;
                        end
                        default: begin
                            if (room) begin
                                wr_en  = 1'b1;
                                n_pos  = r_pos + 1'b1;
                                push   = 1'b1;
                                n_kind = KIND_ECHO;
                                n_char = r_key;
                                n_last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_KILL: begin
                if (slot_free) begin
                    n_pos  = r_pos - 1'b1;
                    push   = 1'b1;
                    n_kind = KIND_ECHO_BS;
                    n_char = KEY_BS;
                    n_last = (r_pos == PW'(1));
                    if (r_pos == PW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LINE: begin
                if (slot_free) begin
                    push   = 1'b1;
                    n_kind = KIND_LINE_CHAR;
                    n_char = r_rd_data;
                    n_last = 1'b0;
                    n_idx  = r_idx + 1'b1;
                    if (r_idx == r_pos - 1'b1) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    push    = 1'b1;
                    n_kind  = KIND_DONE;
                    n_char  = CHAR_NUL;
                    n_last  = 1'b1;
                    n_pos   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Line buffer RAM; the registered read uses the next emit index as its address
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= r_key;
        end
        r_rd_data <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_idx       <= '0;
            r_max_chars <= MAX_CHARS_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_max_chars <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_key <= i_key_code;
        end
        r_kind <= n_kind;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_char_out = r_char;
    assign o_last     = r_last;

endmodule

`default_nettype wire
